>>> hw/rtl/psg_pkg.sv
package psg_pkg;
	localparam int unsigned ChipsDefault = 5;
	localparam int unsigned CfgWidth = 4;
	localparam int unsigned SampleWidth = 13;
	localparam logic [1:0] CfgStep = 2'd0;
	localparam logic [1:0] CfgGain = 2'd1;
	localparam logic [1:0] CfgActive = 2'd2;
	localparam logic [1:0] CfgEnvDis = 2'd3;
	localparam logic [3:0] StepReset = 4'd9;
	localparam logic [3:0] GainReset = 4'd5;
	localparam logic KindWrite = 1'b0;
	localparam logic KindTick = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [2:0] chip;
		logic [3:0] addr;
		logic [7:0] data;
	} psg_req_t;
endpackage

>>> hw/rtl/psg_front.sv
module psg_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  psg_pkg::psg_req_t in_req,
	output logic              q_valid,
	input  logic              q_pop,
	output psg_pkg::psg_req_t q_req
);
	import psg_pkg::*;

	psg_req_t   fifo_q [4];
	logic [1:0] wp_q;
	logic [1:0] rp_q;
	logic [2:0] cnt_q;
	logic       push;

	assign in_stall = (cnt_q == 3'd4);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 3'd0);
	assign q_req    = fifo_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wp_q] <= in_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 2'd1;
			if (q_pop) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'd0, push} - {2'd0, q_pop};
		end
	end
endmodule

>>> hw/rtl/psg_back.sv
module psg_back #(
	parameter int unsigned CHIPS = psg_pkg::ChipsDefault
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 q_valid,
	output logic                                 q_pop,
	input  psg_pkg::psg_req_t                    q_req,
	input  logic [3:0]                           step_inc,
	input  logic [3:0]                           gain,
	input  logic [2:0]                           active,
	input  logic                                 env_dis,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [psg_pkg::SampleWidth-1:0] out_sample
);
	import psg_pkg::*;

	localparam int unsigned CW = (CHIPS > 1) ? $clog2(CHIPS) : 1;
	localparam int unsigned VW = $clog2(CHIPS * 3);
	localparam int unsigned AW = $clog2(CHIPS * 16);

	typedef enum logic [2:0] {
		ST_IDLE, ST_LOAD, ST_CHIP, ST_VOICE, ST_DONE
	} st_t;

	logic [7:0]  rf_q [CHIPS*16];
	logic [CHIPS*16-1:0] rf_vld_q;
	logic [7:0]  rd_data_q;
	logic        rd_vld_q;
	logic [7:0]  loc_q [14];
	logic [12:0] tcnt_q [CHIPS*3];
	logic [CHIPS*3-1:0] tph_q;
	logic [5:0]  ncnt_q [CHIPS];
	logic [17:0] nsh_q [CHIPS];
	logic [16:0] ecnt_q [CHIPS];
	logic [3:0]  elev_q [CHIPS];
	logic [CHIPS-1:0] ehld_q;
	logic [3:0]  eshp_q [CHIPS];

	st_t         st_q;
	logic [CW-1:0] k_q;
	logic [1:0]  c_q;
	logic [3:0]  fa_q;
	logic [3:0]  n_q;
	logic signed [SampleWidth-1:0] sum_q;

	logic          wr_en;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;

	logic [VW-1:0] v;
	logic [7:0]  plo, phi, vol, mixer;
	logic [11:0] period;
	logic [1:0]  en;
	logic        run, hi;
	logic [3:0]  lvl;
	logic [7:0]  prod;
	logic [12:0] tn;

	logic [3:0]  shp;
	logic [15:0] eper;
	logic [4:0]  nper;
	logic [3:0]  el0;
	logic        eh0;
	logic [16:0] ec1;
	logic [16:0] ec2;
	logic [5:0]  nc1;
	logic [3:0]  el_nx;
	logic        eh_nx;
	logic [16:0] ec_nx;
	logic [5:0]  nc_nx;
	logic [17:0] ns_nx;

	assign wr_en = q_pop && q_req.kind == KindWrite && q_req.chip < CHIPS;
	assign waddr = AW'({q_req.chip[CW-1:0], q_req.addr});
	assign raddr = AW'({k_q, fa_q});

	assign v  = VW'(k_q * 3 + c_q);
	assign shp  = loc_q[13][3:0];
	assign eper = {loc_q[12], loc_q[11]};
	assign nper = loc_q[6][4:0];
	assign plo  = loc_q[{1'b0, c_q, 1'b0}];
	assign phi  = loc_q[{1'b0, c_q, 1'b1}];
	assign vol  = loc_q[4'd8 + {2'd0, c_q}];
	assign mixer = loc_q[7];
	assign period = {phi[3:0], plo};
	assign en  = ~{mixer[c_q + 3], mixer[c_q]};
	assign run = (period != 0 || (vol[4] && !env_dis)) && vol != 0 && en != 0;
	assign lvl = vol[4] ? elev_q[k_q] : vol[3:0];
	assign hi  = (!en[0] || tph_q[v]) && (!en[1] || nsh_q[k_q][0]);
	assign prod = gain * lvl;
	assign tn  = tcnt_q[v] + 13'(step_inc);

	always_comb begin
		el0 = elev_q[k_q];
		eh0 = ehld_q[k_q];
		ec1 = ecnt_q[k_q];
		if (shp != eshp_q[k_q]) begin
			ec1 = '0;
			el0 = (shp < 4 || (shp >= 8 && shp < 12)) ? 4'd0 : 4'd15;
			eh0 = 1'b0;
		end
		el_nx = el0;
		eh_nx = eh0;
		ec_nx = ec1;
		ec2 = ec1 + 17'(step_inc);
		if (!eh0 && eper != 16'd0) begin
			if (ec2 >= {1'b0, eper}) begin
				ec_nx = ec2 - {1'b0, eper};
				if (shp < 4'd8) begin
					if (el0 == 4'd15) begin
						el_nx = shp[0] ? 4'd0 : 4'd15;
						if (shp[1]) eh_nx = 1'b1;
					end else el_nx = el0 + 4'd1;
				end else begin
					if (el0 == 4'd0) begin
						el_nx = shp[0] ? 4'd15 : 4'd0;
						if (shp[1]) eh_nx = 1'b1;
					end else el_nx = el0 - 4'd1;
				end
			end else ec_nx = ec2;
		end
		nc1 = ncnt_q[k_q] + 6'(step_inc);
		nc_nx = ncnt_q[k_q];
		ns_nx = nsh_q[k_q];
		if (nper != 5'd0) begin
			if (nc1 > {1'b0, nper}) begin
				nc_nx = nc1 - {1'b0, nper};
				ns_nx = {1'b0, nsh_q[k_q][17] ^ nsh_q[k_q][0] ^ nsh_q[k_q][3],
					nsh_q[k_q][16:1]};
			end else nc_nx = nc1;
		end
	end

	assign q_pop = (st_q == ST_IDLE) && q_valid;
	assign out_valid = (st_q == ST_DONE);
	assign out_sample = sum_q;

	always_ff @(posedge clk) begin
		if (wr_en) rf_q[waddr] <= q_req.data;
		rd_data_q <= rf_q[raddr];
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_LOAD && fa_q != 4'd0)
			loc_q[fa_q - 4'd1] <= rd_vld_q ? rd_data_q : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			k_q   <= '0;
			c_q   <= '0;
			fa_q  <= '0;
			n_q   <= '0;
			sum_q <= '0;
			rf_vld_q <= '0;
			rd_vld_q <= 1'b0;
			tph_q <= '1;
			ehld_q <= '0;
			for (int i = 0; i < CHIPS*3; i++) tcnt_q[i] <= 13'd1;
			for (int i = 0; i < CHIPS; i++) begin
				ncnt_q[i] <= 6'd1;
				nsh_q[i]  <= 18'd1;
				ecnt_q[i] <= '0;
				elev_q[i] <= '0;
				eshp_q[i] <= '0;
			end
		end else begin
			rd_vld_q <= rf_vld_q[raddr];
			if (wr_en) rf_vld_q[waddr] <= 1'b1;
			unique case (st_q)
				ST_IDLE: begin
					if (q_pop && q_req.kind == KindTick) begin
						sum_q <= '0;
						k_q   <= '0;
						c_q   <= '0;
						fa_q  <= '0;
						n_q   <= (active > CHIPS) ? 4'(CHIPS) : {1'b0, active};
						st_q  <= (active == 0) ? ST_DONE : ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (fa_q == 4'd14) begin
						fa_q <= '0;
						st_q <= ST_CHIP;
					end else fa_q <= fa_q + 4'd1;
				end
				ST_CHIP: begin
					eshp_q[k_q] <= shp;
					elev_q[k_q] <= el_nx;
					ehld_q[k_q] <= eh_nx;
					ecnt_q[k_q] <= ec_nx;
					ncnt_q[k_q] <= nc_nx;
					nsh_q[k_q]  <= ns_nx;
					st_q <= ST_VOICE;
				end
				ST_VOICE: begin
					if (run) begin
						if (lvl != 0)
							sum_q <= hi ? sum_q + SampleWidth'(prod) : sum_q - SampleWidth'(prod);
						if (tn > {1'b0, period}) begin
							tcnt_q[v] <= tn - {1'b0, period};
							tph_q[v]  <= ~tph_q[v];
						end else tcnt_q[v] <= tn;
					end
					if (c_q == 2'd2) begin
						c_q <= '0;
						if (4'(k_q) + 4'd1 == n_q) st_q <= ST_DONE;
						else begin
							k_q  <= k_q + 1'b1;
							st_q <= ST_LOAD;
						end
					end else c_q <= c_q + 2'd1;
				end
				ST_DONE: begin
					if (!out_stall) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

>>> hw/rtl/psg_tone_noise_envelope_core.sv
// channel | direction | signals
// in      | request   | in_valid, in_stall, kind, chip, reg_addr, reg_data
// out     | result    | out_valid, out_stall, sample
// cfg     | write     | cfg_we, cfg_index, cfg_data
// a tick steps the back sequencer through each active chip in turn: per chip it
// loads its registers from the register memory, then one chip update and one per voice
// writes go to the register memory; a stalled result holds the sequencer until accepted
// a four-entry queue decouples request intake from the sequencer and stalls when full
// reset presets all counters and phases; valid bits make the register memory read as zero
module psg_tone_noise_envelope_core #(
	parameter int unsigned CHIPS = psg_pkg::ChipsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [2:0]  chip,
	input  logic [3:0]  reg_addr,
	input  logic [7:0]  reg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [psg_pkg::SampleWidth-1:0] sample,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [psg_pkg::CfgWidth-1:0] cfg_data
);
	import psg_pkg::*;

	psg_req_t   req, qreq;
	logic       qv, qpop;
	logic [3:0] step_q, gain_q;
	logic [2:0] act_q;
	logic       envd_q;

	assign req = '{kind: kind, chip: chip, addr: reg_addr, data: reg_data};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= StepReset;
			gain_q <= GainReset;
			act_q  <= '0;
			envd_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CfgStep:   step_q <= cfg_data;
				CfgGain:   gain_q <= cfg_data;
				CfgActive: act_q  <= cfg_data[2:0];
				CfgEnvDis: envd_q <= cfg_data[0];
				default:   ;
			endcase
		end
	end

	psg_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_req(req), .q_valid(qv), .q_pop(qpop), .q_req(qreq)
	);

	psg_back #(.CHIPS(CHIPS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(qv), .q_pop(qpop), .q_req(qreq),
		.step_inc(step_q), .gain(gain_q), .active(act_q), .env_dis(envd_q),
		.out_valid(out_valid), .out_stall(out_stall), .out_sample(sample)
	);
endmodule

>>> hw/rtl/psg_checker.sv
module psg_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic [12:0] sample
);
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid)
		else $error("request withdrawn under stall");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sample))
		else $error("result dropped under stall");
	a_out_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> !out_valid)
		else $error("result repeated");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($signed(sample) <= 3375 && $signed(sample) >= -3375))
		else $error("sample out of range");
endmodule

bind psg_tone_noise_envelope_core psg_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .sample(sample)
);
